// ===== design/per_flow_min_finish_tag_scheduler_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fair-queueing scheduler
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PER_FLOW_MIN_FINISH_TAG_SCHEDULER_UNIT_ASSERT_SVH
`define PER_FLOW_MIN_FINISH_TAG_SCHEDULER_UNIT_ASSERT_SVH

// property must hold at every clock edge outside reset
`define PFMFTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define PFMFTS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/pfmfts_pkg.sv =====
// ---------------------------------------------------------------------------
// pfmfts_pkg
// Types and constants shared by the scheduler top level and its flow cells.
// ---------------------------------------------------------------------------
package pfmfts_pkg;

  localparam int SLOT_W_MAX = 6;   // up to 64 flow slots
  localparam int KEY_W      = 96;  // {src_addr, dst_addr, src_port, dst_port}
  localparam int TAG_W      = 32;
  localparam int DATA_W     = 192;

  typedef enum logic [2:0] {
    ST_ENQUEUED   = 3'd0,
    ST_DEQUEUED   = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_QUEUE_FULL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_OPEN,
    CMD_PUSH,
    CMD_POP,
    CMD_FREE,
    CMD_HEAD
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [SLOT_W_MAX-1:0]  slot;
    logic [SLOT_W_MAX-1:0]  rank;
    logic [TAG_W-1:0]       tag;
    logic [KEY_W-1:0]       key;
  } cell_cmd_t;

  typedef struct packed {
    logic                   match;
    logic [SLOT_W_MAX-1:0]  match_slot;
    logic                   free;
    logic [SLOT_W_MAX-1:0]  free_slot;
  } look_t;

  typedef struct packed {
    logic                   valid;
    logic [TAG_W-1:0]       tag;
    logic [SLOT_W_MAX-1:0]  rank;
    logic [SLOT_W_MAX-1:0]  slot;
  } best_t;

endpackage

// ===== design/per_flow_min_finish_tag_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// per_flow_min_finish_tag_scheduler_unit
// Fair-queueing packet store: per-flow FIFOs, dequeue of the minimum tag.
// ---------------------------------------------------------------------------
//  channel   dir  tuser            tdata
//  s_axis    in   operation        packet 4-tuple, time, length, weight, tag
//  m_axis    out  status           dequeued packet fields (zero otherwise)
//
// One transaction at a time. Enqueue: search, execute, response. Dequeue:
// search, execute, packet RAM read, head tag refill if the flow stays open,
// response. Search waits for the lookup and minimum search walking the chain
// of FLOW_SLOTS cells; the packet RAM has a single read port.
// Reset clears all flows. A result waits in the output register until taken;
// the next input is accepted once the result is loaded there.
// ---------------------------------------------------------------------------
module per_flow_min_finish_tag_scheduler_unit
  import pfmfts_pkg::*;
#(
  parameter int FLOW_SLOTS       = 16,
  parameter int FLOW_QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [0] operation
  input  logic              s_axis_tuser_i,
  // [31:0] src_addr, [47:32] src_port, [79:48] dst_addr, [95:80] dst_port,
  // [127:96] arrival_time, [143:128] packet_length, [159:144] weight,
  // [191:160] finish_tag
  input  logic [DATA_W-1:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [2:0] status
  output logic [2:0]        m_axis_tuser_o,
  // [31:0] out_src_addr, [47:32] out_src_port, [79:48] out_dst_addr,
  // [95:80] out_dst_port, [127:96] out_arrival_time, [143:128] out_length,
  // [159:144] out_weight, [191:160] out_finish_tag
  output logic [DATA_W-1:0] m_axis_tdata_o
);

  localparam int SW = $clog2(FLOW_SLOTS);
  localparam int PW = $clog2(FLOW_QUEUE_DEPTH);
  localparam int OW = $clog2(FLOW_QUEUE_DEPTH + 1);
  localparam int AW = $clog2(FLOW_SLOTS * FLOW_QUEUE_DEPTH);
  localparam int CW = $clog2(FLOW_SLOTS);
  localparam int RW = 96;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_EXEC, S_RD_DATA, S_HEAD, S_RESP
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     cnt_q;
  logic              op_q;
  logic [DATA_W-1:0] item_q;
  logic [SW-1:0]     slot_q;
  logic              more_q;
  status_e           res_status_q;
  logic [DATA_W-1:0] res_data_q;
  logic              m_valid_q;
  status_e           m_status_q;
  logic [DATA_W-1:0] m_data_q;

  look_t             look_c [FLOW_SLOTS+1];
  best_t             best_c [FLOW_SLOTS+1];
  logic [OW-1:0]     occ_a  [FLOW_SLOTS];
  logic [PW-1:0]     rptr_a [FLOW_SLOTS];
  logic [PW-1:0]     wptr_a [FLOW_SLOTS];
  logic [KEY_W-1:0]  key_a  [FLOW_SLOTS];

  cell_cmd_t         cmd;
  logic [KEY_W-1:0]  item_key;
  logic [SW-1:0]     sel_slot;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [RW-1:0]     ram_wdata, ram_rdata;
  look_t             look_r;
  best_t             best_r;

  function automatic logic [AW-1:0] store_addr(input logic [SW-1:0] s,
                                               input logic [PW-1:0] p);
    store_addr = AW'(s) * AW'(FLOW_QUEUE_DEPTH) + AW'(p);
  endfunction

  // key layout {src_addr, dst_addr, src_port, dst_port}
  assign item_key = {item_q[31:0], item_q[79:48], item_q[47:32], item_q[95:80]};
  assign look_r   = look_c[FLOW_SLOTS];
  assign best_r   = best_c[FLOW_SLOTS];
  assign look_c[0] = '0;
  assign best_c[0] = '0;

  for (genvar g = 0; g < FLOW_SLOTS; g++) begin : g_cell
    pfmfts_cell #(
      .SLOTS (FLOW_SLOTS),
      .DEPTH (FLOW_QUEUE_DEPTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_id_i  (SW'(g)),
      .cmd_i      (cmd),
      .look_key_i (item_key),
      .look_i     (look_c[g]),
      .look_o     (look_c[g+1]),
      .best_i     (best_c[g]),
      .best_o     (best_c[g+1]),
      .occ_o      (occ_a[g]),
      .rptr_o     (rptr_a[g]),
      .wptr_o     (wptr_a[g]),
      .key_o      (key_a[g])
    );
  end

  pfmfts_ram #(
    .WIDTH (RW),
    .DEPTH (FLOW_SLOTS * FLOW_QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    sel_slot = slot_q;
    if (state_q == S_EXEC) begin
      if (op_q) begin
        sel_slot = SW'(best_r.slot);
      end else if (look_r.match) begin
        sel_slot = SW'(look_r.match_slot);
      end else begin
        sel_slot = SW'(look_r.free_slot);
      end
    end
  end

  // RAM word: [31:0] time, [47:32] weight, [63:48] length, [95:64] finish
  assign ram_wdata = {item_q[191:160], item_q[143:128], item_q[159:144],
                      item_q[127:96]};

  always_comb begin
    cmd       = '0;
    cmd.kind  = CMD_NONE;
    cmd.slot  = SLOT_W_MAX'(sel_slot);
    cmd.key   = item_key;
    cmd.tag   = item_q[191:160];
    ram_we    = 1'b0;
    ram_waddr = store_addr(sel_slot, wptr_a[sel_slot]);
    ram_raddr = store_addr(sel_slot, rptr_a[sel_slot]);
    case (state_q)
      S_EXEC: begin
        if (!op_q) begin
          if (look_r.match) begin
            if (occ_a[sel_slot] < OW'(FLOW_QUEUE_DEPTH)) begin
              ram_we   = 1'b1;
              cmd.kind = CMD_PUSH;
            end
          end else if (look_r.free) begin
            ram_we    = 1'b1;
            ram_waddr = store_addr(sel_slot, '0);
            cmd.kind  = CMD_OPEN;
          end
        end else if (best_r.valid) begin
          cmd.rank = best_r.rank;
          cmd.kind = (occ_a[sel_slot] == OW'(1)) ? CMD_FREE : CMD_POP;
        end
      end
      S_HEAD: begin
        cmd.kind = CMD_HEAD;
        cmd.tag  = ram_rdata[95:64];
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      op_q         <= 1'b0;
      slot_q       <= '0;
      more_q       <= 1'b0;
      res_status_q <= ST_ENQUEUED;
      res_data_q   <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= ST_ENQUEUED;
      m_data_q     <= '0;
      item_q       <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i && state_q != S_RESP) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q    <= s_axis_tuser_i;
            item_q  <= s_axis_tdata_i;
            cnt_q   <= '0;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // wait until the lookup and search reach the end of the chain
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(FLOW_SLOTS - 1)) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          slot_q     <= sel_slot;
          more_q     <= occ_a[sel_slot] > OW'(1);
          res_data_q <= '0;
          if (!op_q) begin
            state_q <= S_RESP;
            if (look_r.match) begin
              res_status_q <= (occ_a[sel_slot] < OW'(FLOW_QUEUE_DEPTH)) ?
                              ST_ENQUEUED : ST_QUEUE_FULL;
            end else if (look_r.free) begin
              res_status_q <= ST_ENQUEUED;
            end else begin
              res_status_q <= ST_TABLE_FULL;
            end
          end else if (best_r.valid) begin
            res_status_q <= ST_DEQUEUED;
            state_q      <= S_RD_DATA;
          end else begin
            res_status_q <= ST_EMPTY;
            state_q      <= S_RESP;
          end
        end
        S_RD_DATA: begin
          res_data_q <= {ram_rdata[95:64], ram_rdata[47:32], ram_rdata[63:48],
                         ram_rdata[31:0], key_a[slot_q][15:0],
                         key_a[slot_q][63:32], key_a[slot_q][31:16],
                         key_a[slot_q][95:64]};
          state_q    <= more_q ? S_HEAD : S_RESP;
        end
        S_HEAD: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q  <= 1'b1;
            m_status_q <= res_status_q;
            m_data_q   <= res_data_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = m_data_q;

`include "per_flow_min_finish_tag_scheduler_unit_assert.svh"

  `PFMFTS_ASSERT(a_busy_after_accept, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "input accepted while busy")
  `PFMFTS_NEVER(a_zero_payload, m_axis_tvalid_o && m_axis_tuser_o != ST_DEQUEUED && m_axis_tdata_o != '0, "payload on non-dequeue result")
  `PFMFTS_ASSERT(a_result_from_resp, $rose(m_axis_tvalid_o) |-> $past(state_q == S_RESP), "result without response state")

endmodule

// ===== design/pfmfts_ram.sv =====
// ---------------------------------------------------------------------------
// pfmfts_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pfmfts_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pfmfts_cell.sv =====
// ---------------------------------------------------------------------------
// pfmfts_cell
// One flow slot: key, open rank, FIFO pointers and cached head finish tag.
// Passes the key lookup and the minimum-tag search on to its neighbor.
// ---------------------------------------------------------------------------
module pfmfts_cell
  import pfmfts_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int DEPTH = 16,
  localparam int SW   = $clog2(SLOTS),
  localparam int PW   = $clog2(DEPTH),
  localparam int OW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SW-1:0]    slot_id_i,
  input  cell_cmd_t        cmd_i,
  input  logic [KEY_W-1:0] look_key_i,
  input  look_t            look_i,
  output look_t            look_o,
  input  best_t            best_i,
  output best_t            best_o,
  output logic [OW-1:0]    occ_o,
  output logic [PW-1:0]    rptr_o,
  output logic [PW-1:0]    wptr_o,
  output logic [KEY_W-1:0] key_o
);

  logic             active_q;
  logic [SW-1:0]    rank_q;
  logic [OW-1:0]    occ_q;
  logic [PW-1:0]    rptr_q, wptr_q;
  logic [KEY_W-1:0] key_q;
  logic [TAG_W-1:0] head_q;
  look_t            look_q, look_d;
  best_t            best_q, best_d, own;
  logic             tgt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign tgt = (cmd_i.slot == SLOT_W_MAX'(slot_id_i));

  always_comb begin
    look_d = look_i;
    if (!look_i.match && active_q && key_q == look_key_i) begin
      look_d.match      = 1'b1;
      look_d.match_slot = SLOT_W_MAX'(slot_id_i);
    end
    if (!look_i.free && !active_q) begin
      look_d.free      = 1'b1;
      look_d.free_slot = SLOT_W_MAX'(slot_id_i);
    end
  end

  always_comb begin
    own.valid = active_q;
    own.tag   = head_q;
    own.rank  = SLOT_W_MAX'(rank_q);
    own.slot  = SLOT_W_MAX'(slot_id_i);
    best_d    = best_i;
    // smaller tag wins; on a tie the more recently opened flow wins
    if (own.valid && (!best_i.valid || own.tag < best_i.tag ||
        (own.tag == best_i.tag && own.rank < best_i.rank))) begin
      best_d = own;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rank_q   <= '0;
      occ_q    <= '0;
      rptr_q   <= '0;
      wptr_q   <= '0;
      look_q   <= '0;
      best_q   <= '0;
    end else begin
      look_q <= look_d;
      best_q <= best_d;
      case (cmd_i.kind)
        CMD_OPEN: begin
          if (tgt) begin
            active_q <= 1'b1;
            rank_q   <= '0;
            occ_q    <= OW'(1);
            rptr_q   <= '0;
            wptr_q   <= ptr_inc('0);
          end else if (active_q) begin
            rank_q <= rank_q + SW'(1);
          end
        end
        CMD_PUSH: begin
          if (tgt) begin
            occ_q  <= occ_q + OW'(1);
            wptr_q <= ptr_inc(wptr_q);
          end
        end
        CMD_POP: begin
          if (tgt) begin
            occ_q  <= occ_q - OW'(1);
            rptr_q <= ptr_inc(rptr_q);
          end
        end
        CMD_FREE: begin
          if (tgt) begin
            active_q <= 1'b0;
            rank_q   <= '0;
            occ_q    <= '0;
            rptr_q   <= ptr_inc(rptr_q);
          end else if (active_q && SLOT_W_MAX'(rank_q) > cmd_i.rank) begin
            rank_q <= rank_q - SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tgt && cmd_i.kind == CMD_OPEN) begin
      key_q  <= cmd_i.key;
      head_q <= cmd_i.tag;
    end else if (tgt && cmd_i.kind == CMD_HEAD) begin
      head_q <= cmd_i.tag;
    end
  end

  assign look_o = look_q;
  assign best_o = best_q;
  assign occ_o  = occ_q;
  assign rptr_o = rptr_q;
  assign wptr_o = wptr_q;
  assign key_o  = key_q;

endmodule

// ===== tb/tb_per_flow_min_finish_tag_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// tb_per_flow_min_finish_tag_scheduler_unit
// Drives enqueue and dequeue transactions into the fair-queueing store and
// checks every status and dequeued packet against a behavioral flow table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_per_flow_min_finish_tag_scheduler_unit;
  import pfmfts_pkg::*;

  localparam int NSLOT = 16;
  localparam int QDEPTH = 16;
  localparam int LIMIT = 2000000;
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] wgt;
    logic [15:0] len;
    logic [31:0] arr;
    logic [15:0] dport;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [31:0] saddr;
  } pkt_t;

  typedef struct packed {
    status_e stat;
    pkt_t    pkt;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic s_axis_tuser_i = 1'b0;
  logic [DATA_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [2:0] m_axis_tuser_o;
  logic [DATA_W-1:0] m_axis_tdata_o;

  per_flow_min_finish_tag_scheduler_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // flow table mirror
  logic        fl_act [NSLOT];
  logic [95:0] fl_key [NSLOT];
  int          fl_rank [NSLOT];
  pkt_t        fl_q [NSLOT][$];

  sched_result_t pending_results[$];
  int  n_err = 0, n_items = 0, n_deq = 0, n_full = 0, n_empty = 0, n_qfull = 0;
  int  cycle = 0;
  bit  idle_en = 1'b1;

  function automatic sched_result_t predict_sched(logic op, pkt_t p);
    sched_result_t r;
    int slot, best, rk;
    logic [95:0] key;
    r = '0;
    key = {p.dport, p.sport, p.daddr, p.saddr};
    if (op == OP_ENQ) begin
      slot = -1;
      for (int i = 0; i < NSLOT; i++)
        if (slot < 0 && fl_act[i] && fl_key[i] == key) slot = i;
      if (slot < 0) begin
        for (int i = 0; i < NSLOT; i++)
          if (slot < 0 && !fl_act[i]) slot = i;
        if (slot < 0) begin
          r.stat = ST_TABLE_FULL;
          return r;
        end
        for (int i = 0; i < NSLOT; i++) if (fl_act[i]) fl_rank[i]++;
        fl_act[slot] = 1'b1;
        fl_key[slot] = key;
        fl_rank[slot] = 0;
        fl_q[slot].delete();
      end
      if (fl_q[slot].size() >= QDEPTH) begin
        r.stat = ST_QUEUE_FULL;
        return r;
      end
      fl_q[slot].push_back(p);
      r.stat = ST_ENQUEUED;
      return r;
    end
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!fl_act[i] || fl_q[i].size() == 0) continue;
      if (best < 0 || fl_q[i][0].tag < fl_q[best][0].tag ||
          (fl_q[i][0].tag == fl_q[best][0].tag && fl_rank[i] < fl_rank[best]))
        best = i;
    end
    if (best < 0) begin
      r.stat = ST_EMPTY;
      return r;
    end
    r.stat = ST_DEQUEUED;
    r.pkt = fl_q[best].pop_front();
    if (fl_q[best].size() == 0) begin
      rk = fl_rank[best];
      fl_act[best] = 1'b0;
      fl_rank[best] = 0;
      for (int i = 0; i < NSLOT; i++)
        if (fl_act[i] && fl_rank[i] > rk) fl_rank[i]--;
    end
    return r;
  endfunction

  task automatic send_item(logic op, pkt_t p);
    sched_result_t r;
    while (idle_en && $urandom_range(99) < 13) @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= p;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = predict_sched(op, p);
    pending_results.push_back(r);
    n_items++;
    case (r.stat)
      ST_DEQUEUED:   n_deq++;
      ST_EMPTY:      n_empty++;
      ST_TABLE_FULL: n_full++;
      ST_QUEUE_FULL: n_qfull++;
      default: ;
    endcase
    s_axis_tvalid_i <= 1'b0;
    // drop valid between items; the block is not ready again right after an accept anyway
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= !(idle_en && $urandom_range(99) < 13);
  end

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result status=%0d", m_axis_tuser_o);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o !== want.stat || m_axis_tdata_o !== want.pkt) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: status exp %0d got %0d, data exp %h got %h",
                     want.stat, m_axis_tuser_o, want.pkt, m_axis_tdata_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("FAIL per_flow_min_finish_tag_scheduler_unit");
      $finish;
    end
  end

  function automatic pkt_t rand_pkt();
    pkt_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return p;
  endfunction

  // flow keys from a small pool so that packets often join existing flows
  function automatic pkt_t pool_pkt(int id);
    pkt_t p;
    p = rand_pkt();
    p.saddr = 32'h0a00_0000 + id;
    p.daddr = 32'hc0a8_0000 + id * 7;
    p.sport = 16'(1000 + id);
    p.dport = 16'(80 + (id % 3));
    p.tag = $urandom_range(3) == 0 ? 32'(id & 3) : $urandom_range(255);
    return p;
  endfunction

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    pkt_t p;
    send_item(OP_DEQ, rand_pkt());         // empty store
    p = '0;
    send_item(OP_ENQ, p);
    p = '1;
    send_item(OP_ENQ, p);
    send_item(OP_DEQ, '0);
    send_item(OP_DEQ, '1);
    send_item(OP_DEQ, '0);
  endtask

  task automatic test_tie_and_order();
    pkt_t a, b;
    a = pool_pkt(1); a.tag = 32'd50;
    b = pool_pkt(2); b.tag = 32'd50;
    send_item(OP_ENQ, a);
    send_item(OP_ENQ, b);                 // opened later, wins the tie
    a.tag = 32'd10;
    send_item(OP_ENQ, a);
    for (int i = 0; i < 4; i++) send_item(OP_DEQ, '0);
  endtask

  task automatic test_full_cases();
    for (int i = 0; i < QDEPTH + 1; i++) send_item(OP_ENQ, pool_pkt(3));
    for (int i = 0; i < NSLOT; i++) send_item(OP_ENQ, pool_pkt(20 + i));
    drain();                              // hold until all results are back
    for (int i = 0; i < NSLOT + QDEPTH + 1; i++) send_item(OP_DEQ, rand_pkt());
  endtask

  task automatic test_random(int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n == count / 3) idle_en = 1'b0;
      if (n == count / 2) idle_en = 1'b1;
      case ($urandom_range(9))
        0:       send_item(OP_ENQ, rand_pkt());
        1, 2, 3: send_item(OP_DEQ, rand_pkt());
        default: send_item(OP_ENQ, pool_pkt($urandom_range(19)));
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      fl_act[i] = 1'b0;
      fl_rank[i] = 0;
      fl_key[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_tie_and_order();
    test_full_cases();
    test_random(370);
    drain();
    repeat (2 * NSLOT + 10) @(posedge clk_i);
    $display("Sent %0d items: %0d dequeued, %0d empty, %0d table full, %0d queue full.",
             n_items, n_deq, n_empty, n_full, n_qfull);
    if (n_err == 0 && pending_results.size() == 0) begin
      $display("PASS per_flow_min_finish_tag_scheduler_unit");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, pending_results.size());
      $display("FAIL per_flow_min_finish_tag_scheduler_unit");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/pfmfts_pkg.sv
design/pfmfts_ram.sv
design/pfmfts_cell.sv
design/per_flow_min_finish_tag_scheduler_unit.sv
tb/tb_per_flow_min_finish_tag_scheduler_unit.sv
